// ----- design/multiplexed_seven_segment_driver_assert.svh -----
// Assertion macros used by the checker file of the display driver.
`ifndef MULTIPLEXED_SEVEN_SEGMENT_DRIVER_ASSERT_SVH
`define MULTIPLEXED_SEVEN_SEGMENT_DRIVER_ASSERT_SVH

// Same-cycle implication, held off while reset is asserted.
`define MSSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("display driver check failed in the same cycle");

// Next-cycle implication, held off while reset is asserted.
`define MSSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("display driver check failed in the following cycle");

`endif

// ----- design/mssd_pkg.sv -----
`timescale 1ns / 1ps

package mssd_pkg;

    // Field widths of the stream beats.
    localparam int VALUE_W     = 31;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 16;
    localparam int SEG_W       = 7;
    localparam int BYTE_W      = 8;
    localparam int SELECT_W    = 4;
    localparam int BCD_DIGIT_W = 4;
    localparam int STEP_CNT_W  = 5;
    localparam int BITPOS_W    = 4;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] ADDR_DISPLAY_ENABLE = 3'd0;

    // Item kinds carried in tuser.
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_LOAD = 1'b1;

    // Serializer bit position codes.
    localparam logic [BITPOS_W-1:0] BITPOS_IDLE  = 4'd0;
    localparam logic [BITPOS_W-1:0] BITPOS_FIRST = 4'd1;
    localparam logic [BITPOS_W-1:0] BITPOS_LATCH = 4'd9;

    // Binary to decimal converter states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_DONE
    } t_conv_state;

    // Status handed from the converter to the top level.
    typedef struct packed {
        logic busy;
        logic done;
    } t_conv_status;

    // Segment pattern of one decimal digit, segment a in bit 0.
    function automatic logic [SEG_W-1:0] seg_pattern(input logic [BCD_DIGIT_W-1:0] digit);
        logic [SEG_W-1:0] pat;
        case (digit)
            4'd0:    pat = 7'h3f;
            4'd1:    pat = 7'h06;
            4'd2:    pat = 7'h5b;
            4'd3:    pat = 7'h4f;
            4'd4:    pat = 7'h66;
            4'd5:    pat = 7'h6d;
            4'd6:    pat = 7'h7d;
            4'd7:    pat = 7'h07;
            4'd8:    pat = 7'h7f;
            4'd9:    pat = 7'h67;
            default: pat = '0;
        endcase
        return pat;
    endfunction

endpackage

// ----- design/mssd_bcd_conv.sv -----
`timescale 1ns / 1ps

module mssd_bcd_conv #(
    parameter int DIGIT_COUNT = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [mssd_pkg::VALUE_W-1:0]  i_value,
    output mssd_pkg::t_conv_status        o_status,
    output logic [4*DIGIT_COUNT-1:0]      o_digits
);
    import mssd_pkg::*;

    localparam int BCD_W = BCD_DIGIT_W * DIGIT_COUNT;

    t_conv_state             r_state;
    t_conv_state             n_state;
    logic [VALUE_W-1:0]      r_bin;
    logic [BCD_W-1:0]        r_bcd;
    logic [BCD_W-1:0]        w_adj;
    logic [STEP_CNT_W-1:0]   r_count;
    logic                    w_last;

    assign w_last = (r_count == STEP_CNT_W'(VALUE_W - 1));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                if (w_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Status outputs.
    always_comb begin
        o_status.busy = (r_state != ST_IDLE);
        o_status.done = (r_state == ST_DONE);
    end

    // Each decimal digit of five or more gets three added before the doubling.
    always_comb begin
        for (int k = 0; k < DIGIT_COUNT; k++) begin
            if (r_bcd[k*BCD_DIGIT_W +: BCD_DIGIT_W] >= 4'd5) begin
                w_adj[k*BCD_DIGIT_W +: BCD_DIGIT_W] =
                    r_bcd[k*BCD_DIGIT_W +: BCD_DIGIT_W] + 4'd3;
            end else begin
                w_adj[k*BCD_DIGIT_W +: BCD_DIGIT_W] =
                    r_bcd[k*BCD_DIGIT_W +: BCD_DIGIT_W];
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Shift one binary bit into the decimal register per cycle, most significant first.
    // Carries out of the top digit drop, which keeps the lowest digits only.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            if (i_start) begin
                r_bin   <= i_value;
                r_bcd   <= '0;
                r_count <= '0;
            end
        end else if (r_state == ST_SHIFT) begin
            r_bcd   <= {w_adj[BCD_W-2:0], r_bin[VALUE_W-1]};
            r_bin   <= {r_bin[VALUE_W-2:0], 1'b0};
            r_count <= r_count + 1'b1;
        end
    end

    assign o_digits = r_bcd;

endmodule

// ----- design/multiplexed_seven_segment_driver.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Signals                         Payload
// s_axis    in         tvalid tready tdata tuser       tuser = func, tdata = value
// m_axis    out        tvalid tready tdata             serializer result
// apb       in/out     psel penable pwrite paddr ...   display_enable at address 0
//
// A tick beat's result is computed combinationally and held in the output register.
// A load beat runs the bit-serial binary to decimal converter, one shift per value bit
// and then a store step, and s_axis_tready stays low until the converter is idle again.
// A new beat is taken when the converter is idle and the output register is empty or drains
// in that cycle. Reset is synchronous, clears the pattern store and serializer state and arms the frame start.
module multiplexed_seven_segment_driver #(
    parameter int DIGIT_COUNT = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input stream.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [30:0] value, [31] zero fill
    input  logic [mssd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [0] func
    input  logic                              s_axis_tuser,
    // Result stream.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] serial_data, [1] shift_strobe, [2] latch_strobe, [6:3] digit_select,
    // [7] busy_res, [8] outputs_enabled, [15:9] zero fill
    output logic [mssd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mssd_pkg::PADDR_W-1:0]      paddr,
    input  logic [mssd_pkg::PDATA_W-1:0]      pwdata,
    output logic [mssd_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);
    import mssd_pkg::*;

    localparam int DW    = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam int RES_W = 9;

    // Serializer state.
    logic                  r_enable;
    logic                  r_pending;
    logic                  n_pending;
    logic                  r_busy;
    logic                  n_busy;
    logic [BITPOS_W-1:0]   r_bitpos;
    logic [BITPOS_W-1:0]   n_bitpos;
    logic [BYTE_W-1:0]     r_shift;
    logic [BYTE_W-1:0]     n_shift;
    logic [DW-1:0]         r_next_digit;
    logic [DW-1:0]         n_next_digit;
    logic [DW-1:0]         w_nd_inc;
    logic [SELECT_W-1:0]   r_onehot;
    logic [SELECT_W-1:0]   n_onehot;
    logic                  n_data;
    logic                  n_strobe;
    logic                  n_latch;
    logic [SEG_W-1:0]      r_pat [DIGIT_COUNT];

    // Output register.
    logic                  r_m_valid;
    logic [RES_W-1:0]      r_m_res;
    logic [RES_W-1:0]      w_res;

    // Handshakes.
    logic                  w_take;
    logic                  w_is_tick;
    logic                  w_tick;
    logic                  w_load;
    logic                  w_cfg_wr;

    // Converter link.
    t_conv_status               w_conv_status;
    logic [4*DIGIT_COUNT-1:0]   w_digits;

    assign w_is_tick     = (s_axis_tuser == FUNC_TICK);
    assign s_axis_tready = !w_conv_status.busy && (!r_m_valid || m_axis_tready);
    assign w_take        = s_axis_tvalid && s_axis_tready;
    assign w_tick        = w_take && w_is_tick;
    assign w_load        = w_take && !w_is_tick;
    assign w_cfg_wr      = psel && penable && pwrite && pready;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_DISPLAY_ENABLE) ? PDATA_W'(r_enable) : '0;

    mssd_bcd_conv #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_bcd_conv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_load),
        .i_value  (s_axis_tdata[VALUE_W-1:0]),
        .o_status (w_conv_status),
        .o_digits (w_digits)
    );

    assign w_nd_inc = (r_next_digit == DW'(DIGIT_COUNT - 1)) ? '0 : r_next_digit + 1'b1;

    // Serializer step for one tick while enabled: an optional frame start, then a data bit or the latch.
    always_comb begin
        n_pending    = r_pending;
        n_busy       = r_busy;
        n_bitpos     = r_bitpos;
        n_shift      = r_shift;
        n_next_digit = r_next_digit;
        n_onehot     = r_onehot;
        n_data       = 1'b0;
        n_strobe     = 1'b0;
        n_latch      = 1'b0;
        if (r_enable) begin
            if (r_pending) begin
                n_busy       = 1'b1;
                n_pending    = 1'b0;
                n_next_digit = w_nd_inc;
                n_shift      = {1'b0, r_pat[w_nd_inc]};
                n_bitpos     = BITPOS_FIRST;
            end
            if (n_bitpos >= BITPOS_LATCH) begin
                if (int'(n_next_digit) < SELECT_W) begin
                    n_onehot = SELECT_W'(1) << n_next_digit;
                end else begin
                    n_onehot = '0;
                end
                n_latch   = 1'b1;
                n_bitpos  = BITPOS_IDLE;
                n_busy    = 1'b0;
                n_pending = 1'b1;
            end else if (n_bitpos != BITPOS_IDLE) begin
                n_data   = n_shift[0];
                n_strobe = 1'b1;
                n_shift  = {1'b0, n_shift[BYTE_W-1:1]};
                n_bitpos = n_bitpos + 1'b1;
            end
        end
    end

    // Result of the beat; a load only reports the current state.
    always_comb begin
        if (w_is_tick) begin
            w_res = {r_enable, n_busy, n_onehot, n_latch, n_strobe, n_data};
        end else begin
            w_res = {r_enable, r_busy, r_onehot, 1'b0, 1'b0, 1'b0};
        end
    end

    // Serializer registers and the enable register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable     <= 1'b0;
            r_pending    <= 1'b1;
            r_busy       <= 1'b0;
            r_bitpos     <= BITPOS_IDLE;
            r_shift      <= '0;
            r_next_digit <= '0;
            r_onehot     <= '0;
        end else begin
            if (w_tick) begin
                r_busy       <= n_busy;
                r_bitpos     <= n_bitpos;
                r_shift      <= n_shift;
                r_next_digit <= n_next_digit;
                r_onehot     <= n_onehot;
            end
            if (w_cfg_wr && (paddr == ADDR_DISPLAY_ENABLE)) begin
                r_enable <= pwdata[0];
            end
            // Writing a one re-arms the frame start.
            if (w_cfg_wr && (paddr == ADDR_DISPLAY_ENABLE) && pwdata[0]) begin
                r_pending <= 1'b1;
            end else if (w_tick) begin
                r_pending <= n_pending;
            end
        end
    end

    // Pattern store: position 0 holds the most significant displayed digit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                r_pat[i] <= '0;
            end
        end else if (w_conv_status.done) begin
            for (int k = 0; k < DIGIT_COUNT; k++) begin
                r_pat[DIGIT_COUNT-1-k] <= seg_pattern(w_digits[k*BCD_DIGIT_W +: BCD_DIGIT_W]);
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_take) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_m_res <= w_res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_m_res);

endmodule

// ----- design/mssd_checker.sv -----
`timescale 1ns / 1ps
`include "multiplexed_seven_segment_driver_assert.svh"

module mssd_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              s_axis_tuser,
    input logic                              m_axis_tvalid,
    input logic [mssd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import mssd_pkg::*;

    // A beat never carries both a data bit and the latch pulse.
    `MSSD_ASSERT_NOW(a_strobe_excl, i_clk, i_rst_n, m_axis_tvalid, !(m_axis_tdata[1] && m_axis_tdata[2]))

    // At most one digit is lit.
    `MSSD_ASSERT_NOW(a_select_onehot, i_clk, i_rst_n, m_axis_tvalid, $onehot0(m_axis_tdata[6:3]))

    // The latch ends the byte, so busy is clear in that beat.
    `MSSD_ASSERT_NOW(a_latch_idle, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[2], !m_axis_tdata[7])

    // A load closes the input once the converter has started.
    `MSSD_ASSERT_NEXT(a_load_holds, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_LOAD), !s_axis_tready)

endmodule

bind multiplexed_seven_segment_driver mssd_checker u_mssd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata)
);
